@@ hdl/bdw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdw_pkg
// Shared types and constants for the bounded deque window block.
// ----------------------------------------------------------------------------
package bdw_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int VALUE_W       = 64;
   localparam int OP_W          = 3;
   localparam int CAP_W         = 6;
   localparam int COUNT_W       = 6;
   localparam int CAP_RESET     = 32;

   typedef logic [OP_W-1:0]            op_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [CAP_W-1:0]           cap_type;
   typedef logic [COUNT_W-1:0]         count_type;

   localparam op_type OP_PUSH_BACK  = 3'd0;
   localparam op_type OP_PUSH_FRONT = 3'd1;
   localparam op_type OP_POP_BACK   = 3'd2;
   localparam op_type OP_POP_FRONT  = 3'd3;
   localparam op_type OP_CLEAR      = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;   // item accepted this cycle
      logic finish;  // memory read data is available this cycle
   } cmd_type;

endpackage : bdw_pkg
`default_nettype wire

@@ hdl/bdw_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdw_req_if
// Request channel: one deque operation and the value to push.
// ----------------------------------------------------------------------------
interface bdw_req_if;
   logic                valid;
   logic                ready;
   bdw_pkg::op_type     operation;
   bdw_pkg::value_type  value_in;

   modport source (output valid, output operation, output value_in, input ready);
   modport sink   (input valid, input operation, input value_in, output ready);
endinterface : bdw_req_if
`default_nettype wire

@@ hdl/bdw_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdw_rsp_if
// Response channel: popped value and the window state after the operation.
// ----------------------------------------------------------------------------
interface bdw_rsp_if;
   logic                valid;
   logic                ready;
   bdw_pkg::value_type  popped_value;
   logic                popped_valid;
   bdw_pkg::count_type  entry_count;
   bdw_pkg::value_type  front_value;
   bdw_pkg::value_type  back_value;

   modport source (output valid, output popped_value, output popped_valid,
                   output entry_count, output front_value, output back_value,
                   input ready);
   modport sink   (input valid, input popped_value, input popped_valid,
                   input entry_count, input front_value, input back_value,
                   output ready);
endinterface : bdw_rsp_if
`default_nettype wire

@@ hdl/bdw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdw_ctrl
// Sequencer: accept an item, wait for the slot read, then hold the response.
// ----------------------------------------------------------------------------
module bdw_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bdw_pkg::cmd_type      cmd
);
   import bdw_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SEND  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_SEND);
   assign cmd.start  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.finish = (state_ff == ST_FETCH);

endmodule : bdw_ctrl
`default_nettype wire

@@ hdl/bdw_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdw_datapath
// Ring of slots with head pointer, fill count, and cached front and back
// entries. At most one slot write and one registered slot read per item.
// ----------------------------------------------------------------------------
module bdw_datapath #(
   parameter int DEPTH = bdw_pkg::DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bdw_pkg::cmd_type    cmd,
   input  wire bdw_pkg::op_type     operation,
   input  wire bdw_pkg::value_type  value_in,
   input  wire logic                csr_write_enable,
   input  wire bdw_pkg::cap_type    csr_write_data,
   output bdw_pkg::value_type       popped_value,
   output logic                     popped_valid,
   output bdw_pkg::count_type       entry_count,
   output bdw_pkg::value_type       front_value,
   output bdw_pkg::value_type       back_value
);
   import bdw_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

   typedef logic [AW-1:0] addr_type;
   typedef logic [CW-1:0] cnt_type;

   function automatic addr_type wrap_add(input addr_type a, input addr_type b);
      logic [AW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
      return sum[AW-1:0];
   endfunction

   value_type mem [DEPTH];

   addr_type  head_ff, head_in;
   cnt_type   count_ff, count_in;
   cnt_type   cap_ff, cap_in;
   value_type front_ff, back_ff;
   value_type rd_data_ff;
   value_type popped_value_ff, popped_value_in;
   logic      popped_valid_ff, popped_valid_in;
   logic      refresh_front_ff, refresh_front_in;
   logic      refresh_back_ff, refresh_back_in;
   logic      set_front, set_back;
   logic      wr_en;
   logic      full;
   addr_type  tail_pos, wr_addr, rd_addr;

   // Effective capacity: zero reads as one, anything above DEPTH saturates.
   always_comb begin
      if (csr_write_data == '0) begin
         cap_in = cnt_type'(1);
      end else if (int'(csr_write_data) > DEPTH) begin
         cap_in = cnt_type'(DEPTH);
      end else begin
         cap_in = cnt_type'(csr_write_data);
      end
   end

   always_comb begin
      full             = (count_ff >= cap_ff);
      head_in          = head_ff;
      count_in         = count_ff;
      popped_value_in  = '0;
      popped_valid_in  = 1'b0;
      refresh_front_in = 1'b0;
      refresh_back_in  = 1'b0;
      set_front        = 1'b0;
      set_back         = 1'b0;
      wr_en            = 1'b0;
      case (operation)
         OP_PUSH_BACK: begin
            if (full) begin
               head_in  = wrap_add(head_ff, addr_type'(1));
               count_in = cap_ff;
            end else begin
               count_in = count_ff + cnt_type'(1);
            end
            wr_en    = 1'b1;
            set_back = 1'b1;
            if (count_in == cnt_type'(1)) begin
               set_front = 1'b1;
            end else if (full) begin
               refresh_front_in = 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            count_in  = full ? cap_ff : count_ff + cnt_type'(1);
            head_in   = (head_ff == '0) ? addr_type'(DEPTH - 1) : head_ff - addr_type'(1);
            wr_en     = 1'b1;
            set_front = 1'b1;
            if (count_in == cnt_type'(1)) begin
               set_back = 1'b1;
            end else if (full) begin
               refresh_back_in = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (count_ff != '0) begin
               popped_value_in = back_ff;
               popped_valid_in = 1'b1;
               count_in        = count_ff - cnt_type'(1);
               refresh_back_in = (count_in != '0);
            end
         end
         OP_POP_FRONT: begin
            if (count_ff != '0) begin
               popped_value_in  = front_ff;
               popped_valid_in  = 1'b1;
               head_in          = wrap_add(head_ff, addr_type'(1));
               count_in         = count_ff - cnt_type'(1);
               refresh_front_in = (count_in != '0);
            end
         end
         OP_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
      // Position of the back entry after the operation; only used when
      // the window holds at least one entry.
      tail_pos = wrap_add(head_in, addr_type'(count_in - cnt_type'(1)));
      wr_addr  = (operation == OP_PUSH_FRONT) ? head_in : tail_pos;
      rd_addr  = refresh_front_in ? head_in : tail_pos;
   end

   always_ff @(posedge clock) begin
      if (cmd.start && wr_en) begin
         mem[wr_addr] <= value_in;
      end
      if (cmd.start) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff          <= '0;
         count_ff         <= '0;
         cap_ff           <= cnt_type'(CAP_INIT);
         refresh_front_ff <= 1'b0;
         refresh_back_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         head_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= cap_in;
      end else if (cmd.start) begin
         head_ff          <= head_in;
         count_ff         <= count_in;
         refresh_front_ff <= refresh_front_in;
         refresh_back_ff  <= refresh_back_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         popped_value_ff <= popped_value_in;
         popped_valid_ff <= popped_valid_in;
         if (set_front) front_ff <= value_in;
         if (set_back)  back_ff  <= value_in;
      end else if (cmd.finish) begin
         if (refresh_front_ff) front_ff <= rd_data_ff;
         if (refresh_back_ff)  back_ff  <= rd_data_ff;
      end
   end

   assign popped_value = popped_value_ff;
   assign popped_valid = popped_valid_ff;
   assign entry_count  = count_type'(count_ff);
   assign front_value  = (count_ff == '0) ? value_type'(0) : front_ff;
   assign back_value   = (count_ff == '0) ? value_type'(0) : back_ff;

endmodule : bdw_datapath
`default_nettype wire

@@ hdl/bounded_deque_window_core.sv @@
`default_nettype none
// Result: once an item is accepted, the controller passes through its fetch
// state into its send state, where the result is presented until taken.
// Flow: one item at a time; a new item is accepted only after the result is
// taken, paced by the registered read of the slot memory and the send state.
// Reset: synchronous; the window is empty, head at zero, capacity at 32
// (or DEPTH if smaller). Slot contents are not cleared by reset.
// ----------------------------------------------------------------------------
// bounded_deque_window_core
// Bounded double-ended queue of signed 64-bit values with overwrite on a full
// window and a programmable capacity.
// ----------------------------------------------------------------------------
module bounded_deque_window_core #(
   parameter int DEPTH = bdw_pkg::DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   bdw_req_if.sink                req,
   bdw_rsp_if.source              rsp,
   input  wire logic              csr_write_enable,
   input  wire bdw_pkg::cap_type  csr_write_data
);
   import bdw_pkg::*;

   cmd_type cmd;

   bdw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   bdw_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .operation        (req.operation),
      .value_in         (req.value_in),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .popped_value     (rsp.popped_value),
      .popped_valid     (rsp.popped_valid),
      .entry_count      (rsp.entry_count),
      .front_value      (rsp.front_value),
      .back_value       (rsp.back_value)
   );

endmodule : bounded_deque_window_core
`default_nettype wire

@@ tb/bounded_deque_window_core_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_window_core_tb
// Self-checking bench for the bounded deque window. A short directed table
// covers empty pops, extreme values, unused operation codes, clear and the
// smallest capacities. Random traffic then runs in phases at several capacity
// settings. An item-level model of the ring tracks every accepted item, and
// each response is compared field by field, in order, with its prediction.
// ----------------------------------------------------------------------------
module bounded_deque_window_core_tb;
   import bdw_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RING_DEPTH     = DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES  = 6;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_ITEMS    = 92;

   // The block does nothing on these codes; the package leaves them unnamed.
   localparam op_type OP_UNUSED_5 = 3'd5;
   localparam op_type OP_UNUSED_6 = 3'd6;
   localparam op_type OP_UNUSED_7 = 3'd7;

   localparam value_type VALUE_MAX = {1'b0, {63{1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {63{1'b0}}};

   typedef struct packed {
      value_type popped_value;
      logic      popped_valid;
      count_type entry_count;
      value_type front_value;
      value_type back_value;
   } deque_result_type;

   typedef enum logic [1:0] {ROW_WRITE_CAP, ROW_CHECKED, ROW_PINNED} row_kind_type;
   typedef enum logic [1:0] {MODE_GROW, MODE_SHRINK, MODE_EVEN} traffic_mode_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_RARE, STALL_HOLD} stall_mode_type;

   typedef struct packed {
      row_kind_type     kind;
      op_type           op;
      value_type        value;
      deque_result_type fixed;
   } table_row_type;

   localparam deque_result_type NO_RESULT = '0;

   logic      clock = 1'b0;
   logic      reset;
   logic      csr_write_enable;
   cap_type   csr_write_data;

   bdw_req_if req_ch ();
   bdw_rsp_if rsp_ch ();

   bounded_deque_window_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Window model: ring storage, head pointer, fill count and capacity.
   value_type ring_mem [RING_DEPTH];
   int        ring_head;
   int        ring_fill;
   cap_type   cap_setting;

   deque_result_type expected_q [$];
   table_row_type    sent_rows_q [$];
   int               mismatch_count = 0;
   int               burst_left = 0;

   function automatic deque_result_type apply_operation(op_type op, value_type v);
      deque_result_type r;
      int               limit;
      r = NO_RESULT;
      if (cap_setting == 0)
         limit = 1;
      else if (cap_setting > RING_DEPTH)
         limit = RING_DEPTH;
      else
         limit = cap_setting;
      case (op)
         OP_PUSH_BACK: begin
            // A full window loses its oldest entry to make room.
            if (ring_fill >= limit) begin
               ring_head = (ring_head + 1) % RING_DEPTH;
               ring_fill = limit - 1;
            end
            ring_mem[(ring_head + ring_fill) % RING_DEPTH] = v;
            ring_fill++;
         end
         OP_PUSH_FRONT: begin
            // A full window loses its back entry instead.
            if (ring_fill >= limit)
               ring_fill = limit - 1;
            ring_head = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
            ring_mem[ring_head] = v;
            ring_fill++;
         end
         OP_POP_BACK: begin
            if (ring_fill > 0) begin
               r.popped_value = ring_mem[(ring_head + ring_fill - 1) % RING_DEPTH];
               r.popped_valid = 1'b1;
               ring_fill--;
            end
         end
         OP_POP_FRONT: begin
            if (ring_fill > 0) begin
               r.popped_value = ring_mem[ring_head];
               r.popped_valid = 1'b1;
               ring_head = (ring_head + 1) % RING_DEPTH;
               ring_fill--;
            end
         end
         OP_CLEAR: begin
            ring_fill = 0;
            ring_head = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = count_type'(ring_fill);
      if (ring_fill > 0) begin
         r.front_value = ring_mem[ring_head];
         r.back_value  = ring_mem[(ring_head + ring_fill - 1) % RING_DEPTH];
      end
      return r;
   endfunction

   function automatic deque_result_type outcome(value_type pv, logic pvalid, count_type cnt,
                                                value_type fr, value_type bk);
      deque_result_type r;
      r.popped_value = pv;
      r.popped_valid = pvalid;
      r.entry_count  = cnt;
      r.front_value  = fr;
      r.back_value   = bk;
      return r;
   endfunction

   function automatic table_row_type row(row_kind_type kind, op_type op, value_type v,
                                         deque_result_type fixed);
      table_row_type r;
      r.kind  = kind;
      r.op    = op;
      r.value = v;
      r.fixed = fixed;
      return r;
   endfunction

   task automatic check_field(string field, value_type want, value_type got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      deque_result_type got;
      deque_result_type want;
      table_row_type    sent;
      if (reset) begin
         ring_head   = 0;
         ring_fill   = 0;
         cap_setting = cap_type'(CAP_RESET);
      end else begin
         // Responses are checked before this edge's request is predicted.
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.popped_value = rsp_ch.popped_value;
            got.popped_valid = rsp_ch.popped_valid;
            got.entry_count  = rsp_ch.entry_count;
            got.front_value  = rsp_ch.front_value;
            got.back_value   = rsp_ch.back_value;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got count %0d popped %0d",
                        $time, got.entry_count, got.popped_value);
               mismatch_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("popped_value", want.popped_value, got.popped_value);
               check_field("popped_valid", want.popped_valid, got.popped_valid);
               check_field("entry_count", want.entry_count, got.entry_count);
               check_field("front_value", want.front_value, got.front_value);
               check_field("back_value", want.back_value, got.back_value);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            want = apply_operation(req_ch.operation, req_ch.value_in);
            if (sent_rows_q.size() != 0) begin
               sent = sent_rows_q.pop_front();
               if (sent.kind == ROW_PINNED)
                  want = sent.fixed;
            end
            expected_q.push_back(want);
         end
         if (csr_write_enable) begin
            cap_setting = csr_write_data;
            ring_fill   = 0;
            ring_head   = 0;
         end
      end
   end

   // Receiver: switches between always ready, coin flips, rare ready and long holds.
   initial begin : rsp_backpressure
      stall_mode_type mode;
      int             mode_left;
      int             hold;
      rsp_ch.ready = 1'b0;
      mode = STALL_NONE;
      mode_left = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (mode)
            STALL_NONE: rsp_ch.ready <= 1'b1;
            STALL_COIN: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            STALL_RARE: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            default: begin
               if (hold == 0) begin
                  rsp_ch.ready <= 1'b1;
                  hold = $urandom_range(1, 12);
               end else begin
                  rsp_ch.ready <= 1'b0;
                  hold--;
               end
            end
         endcase
      end
   end

   task automatic send_item(table_row_type r);
      int gap;
      sent_rows_q.push_back(r);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.operation <= r.op;
      req_ch.value_in  <= r.value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(cap_type c);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      table_row_type    steps [$];
      cap_type          cap_plan [10];
      traffic_mode_type mode;
      int               mode_left;
      int               push_pct;
      int               roll;
      int               phase;
      int               n;
      int               guard;
      op_type           op;
      value_type        value;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_PUSH_BACK;
      req_ch.value_in  = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity is 32; the first rows start from an empty window.
      steps.push_back(row(ROW_PINNED, OP_POP_FRONT, 0, outcome(0, 0, 0, 0, 0)));
      steps.push_back(row(ROW_PINNED, OP_POP_BACK, VALUE_MAX, outcome(0, 0, 0, 0, 0)));
      steps.push_back(row(ROW_PINNED, OP_UNUSED_5, -1, outcome(0, 0, 0, 0, 0)));
      steps.push_back(row(ROW_PINNED, OP_PUSH_BACK, VALUE_MAX,
                          outcome(0, 0, 1, VALUE_MAX, VALUE_MAX)));
      steps.push_back(row(ROW_PINNED, OP_PUSH_FRONT, VALUE_MIN,
                          outcome(0, 0, 2, VALUE_MIN, VALUE_MAX)));
      steps.push_back(row(ROW_PINNED, OP_PUSH_BACK, -1, outcome(0, 0, 3, VALUE_MIN, -1)));
      steps.push_back(row(ROW_PINNED, OP_PUSH_FRONT, 0, outcome(0, 0, 4, 0, -1)));
      steps.push_back(row(ROW_PINNED, OP_UNUSED_7, VALUE_MIN, outcome(0, 0, 4, 0, -1)));
      steps.push_back(row(ROW_PINNED, OP_UNUSED_6, VALUE_MAX, outcome(0, 0, 4, 0, -1)));
      steps.push_back(row(ROW_PINNED, OP_POP_BACK, 0, outcome(-1, 1, 3, 0, VALUE_MAX)));
      steps.push_back(row(ROW_PINNED, OP_POP_FRONT, 0,
                          outcome(0, 1, 2, VALUE_MIN, VALUE_MAX)));
      steps.push_back(row(ROW_PINNED, OP_CLEAR, VALUE_MAX, outcome(0, 0, 0, 0, 0)));
      steps.push_back(row(ROW_CHECKED, OP_PUSH_FRONT, 64'h0123_4567_89ab_cdef, NO_RESULT));
      steps.push_back(row(ROW_CHECKED, OP_POP_BACK, 0, NO_RESULT));
      // A one-entry window: every push replaces the only entry.
      steps.push_back(row(ROW_WRITE_CAP, OP_CLEAR, 1, NO_RESULT));
      steps.push_back(row(ROW_PINNED, OP_PUSH_BACK, 5, outcome(0, 0, 1, 5, 5)));
      steps.push_back(row(ROW_PINNED, OP_PUSH_BACK, 6, outcome(0, 0, 1, 6, 6)));
      steps.push_back(row(ROW_PINNED, OP_PUSH_FRONT, 7, outcome(0, 0, 1, 7, 7)));
      steps.push_back(row(ROW_PINNED, OP_POP_BACK, 0, outcome(7, 1, 0, 0, 0)));
      steps.push_back(row(ROW_PINNED, OP_POP_FRONT, 0, outcome(0, 0, 0, 0, 0)));
      // A capacity of zero acts as one, and one above the ring saturates.
      steps.push_back(row(ROW_WRITE_CAP, OP_CLEAR, 0, NO_RESULT));
      steps.push_back(row(ROW_CHECKED, OP_PUSH_BACK, 11, NO_RESULT));
      steps.push_back(row(ROW_CHECKED, OP_PUSH_BACK, 12, NO_RESULT));
      steps.push_back(row(ROW_CHECKED, OP_PUSH_FRONT, 13, NO_RESULT));
      steps.push_back(row(ROW_WRITE_CAP, OP_CLEAR, 63, NO_RESULT));
      steps.push_back(row(ROW_CHECKED, OP_PUSH_FRONT, VALUE_MIN, NO_RESULT));
      steps.push_back(row(ROW_CHECKED, OP_POP_FRONT, 0, NO_RESULT));

      foreach (steps[i]) begin
         if (steps[i].kind == ROW_WRITE_CAP)
            write_capacity(cap_type'(steps[i].value));
         else
            send_item(steps[i]);
      end

      cap_plan = '{6'd32, 6'd1, 6'd2, 6'd63, 6'd0, 6'd3, 6'd31, 6'd32, 6'd5, 6'd16};
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 10)
            write_capacity(cap_plan[phase]);
         else
            write_capacity(cap_type'($urandom_range(1, 32)));
         mode_left = 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (mode_left == 0) begin
               mode = traffic_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (phase % 3 == 1 && n == PHASE_ITEMS / 2)
               drain_results();
            case (mode)
               MODE_GROW:   push_pct = 80;
               MODE_SHRINK: push_pct = 25;
               default:     push_pct = 50;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 1)
               op = OP_CLEAR;
            else if (roll < 3)
               op = op_type'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
            else if (roll < 3 + push_pct * 97 / 100)
               op = ($urandom_range(0, 1) == 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
               op = ($urandom_range(0, 1) == 1) ? OP_POP_BACK : OP_POP_FRONT;
            roll = $urandom_range(0, 9);
            if (roll == 0)
               value = VALUE_MAX;
            else if (roll == 1)
               value = VALUE_MIN;
            else if (roll == 2)
               value = -1;
            else
               value = {$urandom, $urandom};
            send_item(row(ROW_CHECKED, op, value, NO_RESULT));
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      for (guard = 0; guard < 5000 && expected_q.size() != 0; guard++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("%0t: run did not finish in time", $time);
      $display("TEST FAILED");
      $finish;
   end

endmodule : bounded_deque_window_core_tb
`default_nettype wire
